/* src/crc_checked_record_parser_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the CRC-checked record parser
// Define NO_ASSERTIONS to compile the checks out.
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_RECORD_PARSER_DEFINES_SVH
`define CRC_CHECKED_RECORD_PARSER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every clock edge outside reset
`define CRP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// condition that must never be seen outside reset
`define CRP_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define CRP_ASSERT(lbl, clk, rst_n, prop)
`define CRP_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* src/crp_pkg.sv */
// ----------------------------------------------------------------------------
// crp_pkg
// Types, codes and the CRC-32 byte step shared by the record parser modules.
// ----------------------------------------------------------------------------
package crp_pkg;

  // Header layout and CRC-32 (IEEE, reflected)
  localparam int          HDR_LEN     = 12;
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES    = 32'hFFFFFFFF;
  localparam int          QUEUE_DEPTH = 4;

  // Configuration register indexes and reset values
  localparam logic [1:0] REG_MAGIC_FIRST      = 2'd0;
  localparam logic [1:0] REG_MAGIC_SECOND     = 2'd1;
  localparam logic [1:0] REG_EXPECTED_VERSION = 2'd2;
  localparam logic [7:0] RST_MAGIC_FIRST      = 8'd71;
  localparam logic [7:0] RST_MAGIC_SECOND     = 8'd83;
  localparam logic [7:0] RST_EXPECTED_VERSION = 8'd1;

  // Field kinds of a decoded result
  localparam logic [4:0] KIND_PAT_COUNT   = 5'd0;
  localparam logic [4:0] KIND_TEMPO       = 5'd1;
  localparam logic [4:0] KIND_CLK_EN      = 5'd2;
  localparam logic [4:0] KIND_PITCH_COUNT = 5'd9;
  localparam logic [4:0] KIND_PITCH_ORDER = 5'd10;
  localparam logic [4:0] KIND_PITCH_ENTRY = 5'd11;
  localparam logic [4:0] KIND_VEL_COUNT   = 5'd12;
  localparam logic [4:0] KIND_VEL_ORDER   = 5'd13;
  localparam logic [4:0] KIND_VEL_ENTRY   = 5'd14;
  localparam logic [4:0] KIND_CHANNEL     = 5'd15;
  localparam logic [4:0] KIND_ACTIVE      = 5'd16;

  // Decoder positions within the payload
  localparam logic [4:0] FP_PAT_COUNT   = 5'd0;
  localparam logic [4:0] FP_TEMPO_LO    = 5'd1;
  localparam logic [4:0] FP_TEMPO_HI    = 5'd2;
  localparam logic [4:0] FP_CLK_EN      = 5'd3;
  localparam logic [4:0] FP_GATE_FIRST  = 5'd4;
  localparam logic [4:0] FP_GATE_LAST   = 5'd9;
  localparam logic [4:0] FP_PITCH_COUNT = 5'd10;
  localparam logic [4:0] FP_PITCH_ORDER = 5'd11;
  localparam logic [4:0] FP_PITCH_ENTRY = 5'd12;
  localparam logic [4:0] FP_VEL_COUNT   = 5'd13;
  localparam logic [4:0] FP_VEL_ORDER   = 5'd14;
  localparam logic [4:0] FP_VEL_ENTRY   = 5'd15;
  localparam logic [4:0] FP_CHANNEL     = 5'd16;
  localparam logic [4:0] FP_ACTIVE      = 5'd17;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_TRAIL
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNC     = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_BAD_VER   = 3'd3,
    ST_CRC       = 3'd4
  } load_status_t;

  // One result item
  typedef struct packed {
    logic        is_status;
    logic [2:0]  load_status;
    logic [4:0]  field_kind;
    logic [3:0]  pattern_index;
    logic [3:0]  element_index;
    logic [15:0] field_value;
    logic        last_of_run;
  } res_t;

  // Results caused by one transfer: a decoded field and/or the status
  typedef struct packed {
    logic field_vld;
    logic status_vld;
    res_t field;
    res_t status;
  } push_t;

  // Advance the CRC register by one byte, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? (CRC_POLY ^ (v >> 1)) : (v >> 1);
    end
    return v;
  endfunction

endpackage

/* src/crp_regs.sv */
// ----------------------------------------------------------------------------
// crp_regs
// APB-style register file holding the expected magic and version bytes.
// ----------------------------------------------------------------------------
module crp_regs
  import crp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  magic_first,
  output logic [7:0]  magic_second,
  output logic [7:0]  expected_version
);

  logic [7:0] magic_first_r;
  logic [7:0] magic_second_r;
  logic [7:0] version_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // Write on the access phase; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_first_r  <= RST_MAGIC_FIRST;
      magic_second_r <= RST_MAGIC_SECOND;
      version_r      <= RST_EXPECTED_VERSION;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_MAGIC_FIRST:      magic_first_r  <= pwdata[7:0];
        REG_MAGIC_SECOND:     magic_second_r <= pwdata[7:0];
        REG_EXPECTED_VERSION: version_r      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[3:2])
      REG_MAGIC_FIRST:      prdata = {24'd0, magic_first_r};
      REG_MAGIC_SECOND:     prdata = {24'd0, magic_second_r};
      REG_EXPECTED_VERSION: prdata = {24'd0, version_r};
      default:              prdata = 32'd0;
    endcase
  end

  assign magic_first      = magic_first_r;
  assign magic_second     = magic_second_r;
  assign expected_version = version_r;

endmodule

/* src/crp_core.sv */
// ----------------------------------------------------------------------------
// crp_core
// Per-byte header check, CRC update, payload decode and end-of-record status.
// ----------------------------------------------------------------------------
`include "crc_checked_record_parser_defines.svh"

module crp_core
  import crp_pkg::*;
#(
  parameter int MAX_PATTERN_SLOTS = 16,
  parameter int MAX_SET_ENTRIES   = 16
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  input  logic [7:0] magic_first,
  input  logic [7:0] magic_second,
  input  logic [7:0] expected_version,
  output push_t      push
);

  localparam logic [7:0] PAT_LIM = 8'(MAX_PATTERN_SLOTS);
  localparam logic [7:0] SET_LIM = 8'(MAX_SET_ENTRIES);

  phase_t      phase_r,    phase_nxt;
  logic [31:0] cnt_r,      cnt_nxt;
  logic [1:0]  flags_r,    flags_nxt;
  logic [31:0] len_r,      len_nxt;
  logic [31:0] chk_r,      chk_nxt;
  logic [31:0] crc_r,      crc_nxt;
  logic [4:0]  fpos_r,     fpos_nxt;
  logic [7:0]  pat_num_r,  pat_num_nxt;
  logic [7:0]  elem_num_r, elem_num_nxt;
  logic [7:0]  pat_tot_r,  pat_tot_nxt;
  logic [7:0]  set_tot_r,  set_tot_nxt;
  logic [7:0]  lo_hold_r,  lo_hold_nxt;
  logic        done_r,     done_nxt;

  logic [7:0]  b;
  logic [7:0]  clamp_v;
  logic [7:0]  inc_v;
  logic        sat;
  logic [32:0] need_len;
  load_status_t st;

  assign b   = in_data_byte;
  assign sat = &cnt_r;

  // Next state and results for the byte at the input
  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    flags_nxt    = flags_r;
    len_nxt      = len_r;
    chk_nxt      = chk_r;
    crc_nxt      = crc_r;
    fpos_nxt     = fpos_r;
    pat_num_nxt  = pat_num_r;
    elem_num_nxt = elem_num_r;
    pat_tot_nxt  = pat_tot_r;
    set_tot_nxt  = set_tot_r;
    lo_hold_nxt  = lo_hold_r;
    done_nxt     = done_r;
    push         = '0;
    clamp_v      = 8'd0;
    inc_v        = 8'd0;
    need_len     = 33'd0;
    st           = ST_OK;

    if (!sat) begin
      unique case (phase_r)
        PH_HEADER: begin
          // check magic/version, collect length and stored CRC
          case (cnt_r[3:0])
            4'd0: if (b != magic_first) flags_nxt[0] = 1'b1;
            4'd1: if (b != magic_second) flags_nxt[0] = 1'b1;
            4'd2: if (b != expected_version) flags_nxt[1] = 1'b1;
            4'd4, 4'd5, 4'd6, 4'd7: len_nxt[{cnt_r[1:0], 3'b000} +: 8] = b;
            4'd8, 4'd9, 4'd10, 4'd11: chk_nxt[{cnt_r[1:0], 3'b000} +: 8] = b;
            default: ;
          endcase
          if (cnt_r >= 32'(HDR_LEN - 1)) begin
            phase_nxt = (len_r == 32'd0) ? PH_TRAIL : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          crc_nxt = crc_byte(crc_r, b);
          // decode only a clean header, until the last pattern is done
          if (flags_r == 2'b00 && !done_r) begin
            push.field_vld             = 1'b1;
            push.field.last_of_run     = 1'b1;
            push.field.pattern_index   = pat_num_r[3:0];
            push.field.field_value     = {8'd0, b};
            case (fpos_r) inside
              FP_PAT_COUNT: begin
                clamp_v                  = (b > PAT_LIM) ? PAT_LIM : b;
                pat_tot_nxt              = clamp_v;
                push.field.field_kind    = KIND_PAT_COUNT;
                push.field.pattern_index = 4'd0;
                push.field.field_value   = {8'd0, clamp_v};
                fpos_nxt                 = FP_TEMPO_LO;
              end
              FP_TEMPO_LO: begin
                // hold the low byte, no result
                lo_hold_nxt     = b;
                push.field_vld  = 1'b0;
                fpos_nxt        = FP_TEMPO_HI;
              end
              FP_TEMPO_HI: begin
                push.field.field_kind    = KIND_TEMPO;
                push.field.pattern_index = 4'd0;
                push.field.field_value   = {b, lo_hold_r};
                fpos_nxt                 = FP_CLK_EN;
              end
              FP_CLK_EN: begin
                push.field.field_kind    = KIND_CLK_EN;
                push.field.pattern_index = 4'd0;
                pat_num_nxt              = 8'd0;
                if (pat_tot_r == 8'd0) begin
                  done_nxt = 1'b1;
                end else begin
                  fpos_nxt = FP_GATE_FIRST;
                end
              end
              [FP_GATE_FIRST:FP_GATE_LAST]: begin
                push.field.field_kind = fpos_r - 5'd1;
                fpos_nxt              = fpos_r + 5'd1;
              end
              FP_PITCH_COUNT, FP_VEL_COUNT: begin
                clamp_v                = (b > SET_LIM) ? SET_LIM : b;
                set_tot_nxt            = clamp_v;
                push.field.field_kind  = (fpos_r == FP_PITCH_COUNT) ? KIND_PITCH_COUNT
                                                                    : KIND_VEL_COUNT;
                push.field.field_value = {8'd0, clamp_v};
                fpos_nxt               = fpos_r + 5'd1;
              end
              FP_PITCH_ORDER, FP_VEL_ORDER: begin
                push.field.field_kind = (fpos_r == FP_PITCH_ORDER) ? KIND_PITCH_ORDER
                                                                   : KIND_VEL_ORDER;
                elem_num_nxt          = 8'd0;
                // skip the entry position for an empty set
                fpos_nxt              = fpos_r + ((set_tot_r != 8'd0) ? 5'd1 : 5'd2);
              end
              FP_PITCH_ENTRY, FP_VEL_ENTRY: begin
                push.field.field_kind    = (fpos_r == FP_PITCH_ENTRY) ? KIND_PITCH_ENTRY
                                                                      : KIND_VEL_ENTRY;
                push.field.element_index = elem_num_r[3:0];
                inc_v                    = elem_num_r + 8'd1;
                elem_num_nxt             = inc_v;
                if (inc_v >= set_tot_r) fpos_nxt = fpos_r + 5'd1;
              end
              FP_CHANNEL: begin
                push.field.field_kind = KIND_CHANNEL;
                fpos_nxt              = FP_ACTIVE;
              end
              default: begin
                // active flag closes a pattern slot
                push.field.field_kind = KIND_ACTIVE;
                inc_v                 = pat_num_r + 8'd1;
                pat_num_nxt           = inc_v;
                if (inc_v >= pat_tot_r) begin
                  done_nxt = 1'b1;
                end else begin
                  fpos_nxt = FP_GATE_FIRST;
                end
              end
            endcase
          end
          if (cnt_r - 32'(HDR_LEN - 1) >= len_r) phase_nxt = PH_TRAIL;
        end
        default: ;
      endcase
      cnt_nxt = cnt_r + 32'd1;
    end

    // End of record: rank the status, then return to the header phase
    if (in_final_byte) begin
      need_len = 33'(HDR_LEN) + {1'b0, len_nxt};
      if (cnt_nxt < 32'(HDR_LEN)) begin
        st = ST_TRUNC;
      end else if (flags_nxt[0]) begin
        st = ST_BAD_MAGIC;
      end else if (flags_nxt[1]) begin
        st = ST_BAD_VER;
      end else if ({1'b0, cnt_nxt} < need_len) begin
        st = ST_TRUNC;
      end else if ((crc_nxt ^ CRC_ONES) != chk_nxt) begin
        st = ST_CRC;
      end else if (!done_nxt) begin
        st = ST_TRUNC;
      end else begin
        st = ST_OK;
      end
      push.status_vld         = 1'b1;
      push.status.is_status   = 1'b1;
      push.status.load_status = st;
      push.status.last_of_run = 1'b1;
      push.field.last_of_run  = 1'b0;

      phase_nxt    = PH_HEADER;
      cnt_nxt      = 32'd0;
      flags_nxt    = 2'b00;
      len_nxt      = 32'd0;
      chk_nxt      = 32'd0;
      crc_nxt      = CRC_ONES;
      fpos_nxt     = FP_PAT_COUNT;
      pat_num_nxt  = 8'd0;
      elem_num_nxt = 8'd0;
      pat_tot_nxt  = 8'd0;
      set_tot_nxt  = 8'd0;
      lo_hold_nxt  = 8'd0;
      done_nxt     = 1'b0;
    end

    // Results leave only with a transfer
    if (!in_fire) begin
      push.field_vld  = 1'b0;
      push.status_vld = 1'b0;
    end
  end

  // Advance the parser state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      cnt_r      <= 32'd0;
      flags_r    <= 2'b00;
      len_r      <= 32'd0;
      chk_r      <= 32'd0;
      crc_r      <= CRC_ONES;
      fpos_r     <= FP_PAT_COUNT;
      pat_num_r  <= 8'd0;
      elem_num_r <= 8'd0;
      pat_tot_r  <= 8'd0;
      set_tot_r  <= 8'd0;
      lo_hold_r  <= 8'd0;
      done_r     <= 1'b0;
    end else if (in_fire) begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      flags_r    <= flags_nxt;
      len_r      <= len_nxt;
      chk_r      <= chk_nxt;
      crc_r      <= crc_nxt;
      fpos_r     <= fpos_nxt;
      pat_num_r  <= pat_num_nxt;
      elem_num_r <= elem_num_nxt;
      pat_tot_r  <= pat_tot_nxt;
      set_tot_r  <= set_tot_nxt;
      lo_hold_r  <= lo_hold_nxt;
      done_r     <= done_nxt;
    end
  end

  // The final byte leaves a fresh record context behind
  `CRP_ASSERT(a_final_clears, clk, rst_n, (in_fire && in_final_byte) |=> (cnt_r == 32'd0 && phase_r == PH_HEADER && crc_r == CRC_ONES && !done_r))
  // Leaving the header phase takes the full twelve header bytes
  `CRP_ASSERT(a_phase_count, clk, rst_n, (phase_r != PH_HEADER) |-> (cnt_r >= 32'(HDR_LEN)))
  // Decoded fields come only from a record whose header matched
  `CRP_NEVER(a_field_bad_hdr, clk, rst_n, push.field_vld && (flags_r != 2'b00))

endmodule

/* src/crp_outq.sv */
// ----------------------------------------------------------------------------
// crp_outq
// Four-entry result queue: takes up to two results per transfer, sends one.
// ----------------------------------------------------------------------------
`include "crc_checked_record_parser_defines.svh"

module crp_outq
  import crp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  head
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  res_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] wp_second;
  logic [1:0]    push_n;
  logic          pop;

  assign push_n    = {1'b0, push.field_vld} + {1'b0, push.status_vld};
  assign pop       = out_valid & out_ready;
  assign wp_second = push.field_vld ? wp_r + PW'(1) : wp_r;

  // Room for a full pair keeps the input open
  assign in_ready  = cnt_r <= CW'(QUEUE_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign head      = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r + PW'(push_n);
    rp_nxt  = rp_r + PW'(pop);
    cnt_nxt = cnt_r + CW'(push_n) - CW'(pop);
  end

  // Store the field first, the status behind it
  always_ff @(posedge clk) begin
    if (push.field_vld) mem[wp_r] <= push.field;
    if (push.status_vld) mem[wp_second] <= push.status;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `CRP_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CW'(QUEUE_DEPTH))
  `CRP_NEVER(a_no_overflow, clk, rst_n, (push_n != 2'd0) && !in_ready)
  `CRP_ASSERT(a_pop_drains, clk, rst_n, (pop && push_n == 2'd0) |=> (cnt_r == $past(cnt_r) - CW'(1)))

endmodule

/* src/crc_checked_record_parser.sv */
// ----------------------------------------------------------------------------
// crc_checked_record_parser
// CRC-32 checked record parser: header check, payload decode, final status.
// ----------------------------------------------------------------------------
// The parser takes one record byte per clock cycle and keeps that rate for as
// long as results are taken. Each header byte is checked, and each payload
// byte is fed to a byte-wide CRC-32 step and decoded in the cycle it is
// transferred. A byte's results (at most a decoded field and, on the final
// byte, the status) enter a four-entry queue that sends one result per
// cycle while results are taken. The input stalls only while fewer than two
// queue entries are free, since a final byte can bring both a field and the
// status. Commit the fields of a record only when its status reads OK.
// ----------------------------------------------------------------------------
module crc_checked_record_parser
  import crp_pkg::*;
#(
  parameter int MAX_PATTERN_SLOTS = 16,
  parameter int MAX_SET_ENTRIES   = 16
)
(
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_status,
  output logic [2:0]  out_load_status,
  output logic [4:0]  out_field_kind,
  output logic [3:0]  out_pattern_index,
  output logic [3:0]  out_element_index,
  output logic [15:0] out_field_value,
  output logic        out_last_of_run,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       in_fire;
  logic [7:0] magic_first;
  logic [7:0] magic_second;
  logic [7:0] expected_version;
  push_t      push;
  res_t       head;

  assign in_fire = in_valid & in_ready;

  crp_regs u_regs (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .magic_first      (magic_first),
    .magic_second     (magic_second),
    .expected_version (expected_version)
  );

  crp_core #(
    .MAX_PATTERN_SLOTS (MAX_PATTERN_SLOTS),
    .MAX_SET_ENTRIES   (MAX_SET_ENTRIES)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_fire          (in_fire),
    .in_data_byte     (in_data_byte),
    .in_final_byte    (in_final_byte),
    .magic_first      (magic_first),
    .magic_second     (magic_second),
    .expected_version (expected_version),
    .push             (push)
  );

  crp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // Unpack the queue head onto the result ports
  assign out_is_status     = head.is_status;
  assign out_load_status   = head.load_status;
  assign out_field_kind    = head.field_kind;
  assign out_pattern_index = head.pattern_index;
  assign out_element_index = head.element_index;
  assign out_field_value   = head.field_value;
  assign out_last_of_run   = head.last_of_run;

endmodule
